FILE: rtl/memory_region_coalescer_macros.svh
// Assertion macros shared by the memory region coalescer modules.
`ifndef MEMORY_REGION_COALESCER_MACROS_SVH
`define MEMORY_REGION_COALESCER_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define MRC_ASSERT_IMPLY(label, trig, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error("memory region coalescer: same-cycle check failed");

// Condition holds in the cycle after the trigger.
`define MRC_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error("memory region coalescer: next-cycle check failed");

`endif

FILE: rtl/mrc_pkg.sv
// Types, constants and the type-code table of the memory region coalescer.
package mrc_pkg;

    localparam int unsigned ADDR_W     = 64;
    localparam int unsigned PAGES_W    = 64;
    localparam int unsigned CODE_W     = 5;
    localparam int unsigned INDEX_W    = 16;
    localparam int unsigned PAGE_SHIFT = 12;
    localparam logic [INDEX_W-1:0] INDEX_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_AVAILABLE = 2'd0,
        KIND_UNUSABLE  = 2'd1,
        KIND_ACPI      = 2'd2
    } kind_t;

    // Descriptor as held in the input register, with its end address precomputed.
    typedef struct packed {
        logic [ADDR_W-1:0]  start_addr;
        logic [PAGES_W-1:0] pages;
        logic [ADDR_W-1:0]  end_addr;
        kind_t              kind;
        logic               last_flag;
    } item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  start_addr;
        logic [PAGES_W-1:0] pages;
        kind_t              kind;
        logic [INDEX_W-1:0] index;
        logic               final_flag;
    } result_t;

    // Up to two result beats handed to the output queue in one cycle.
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

    function automatic kind_t kind_of(input logic [CODE_W-1:0] code);
        kind_t k;
        case (code)
            5'd1, 5'd2, 5'd3, 5'd4, 5'd7: k = KIND_AVAILABLE;
            5'd9:                         k = KIND_ACPI;
            default:                      k = KIND_UNUSABLE;
        endcase
        return k;
    endfunction

endpackage

FILE: rtl/mrc_in_stage.sv
// Input register: captures a descriptor, maps its type code and forms its end address.
module mrc_in_stage
    import mrc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [ADDR_W-1:0]    in_start,
    input  logic [PAGES_W-1:0]   in_pages,
    input  logic [CODE_W-1:0]    in_code,
    input  logic                 in_last,
    input  logic                 take,
    output logic                 item_valid,
    output item_t                item
);

    logic  valid_reg, valid_next;
    item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_tvalid && s_tready) begin
            item_reg.start_addr <= in_start;
            item_reg.pages      <= in_pages;
            item_reg.end_addr   <= in_start + (in_pages << PAGE_SHIFT);
            item_reg.kind       <= kind_of(in_code);
            item_reg.last_flag  <= in_last;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: rtl/mrc_merge.sv
// Pending region and merge decision: turns one descriptor into zero, one or two regions.
`include "memory_region_coalescer_macros.svh"
module mrc_merge
    import mrc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       item_valid,
    input  item_t      item,
    input  logic [1:0] free_slots,
    output logic       fire,
    output push_t      push
);

    logic               pv_reg, pv_next;
    logic [ADDR_W-1:0]  pstart_reg, pstart_next;
    logic [PAGES_W-1:0] ppages_reg, ppages_next;
    logic [ADDR_W-1:0]  pend_reg, pend_next;
    kind_t              pkind_reg, pkind_next;
    logic [INDEX_W-1:0] cnt_reg, cnt_next;

    logic               merge;
    logic [PAGES_W-1:0] sum_pages;
    logic [INDEX_W-1:0] cnt1, cnt2;
    logic [1:0]         need;
    result_t            pend_res, cur_res;

    assign merge     = pv_reg && (pkind_reg == item.kind) && (pend_reg == item.start_addr);
    assign sum_pages = ppages_reg + item.pages;
    assign cnt1      = (cnt_reg == INDEX_MAX) ? cnt_reg : cnt_reg + 16'd1;
    assign cnt2      = (cnt1 == INDEX_MAX) ? cnt1 : cnt1 + 16'd1;

    always_comb begin
        if (merge) begin
            need = {1'b0, item.last_flag};
        end else begin
            need = {1'b0, pv_reg} + {1'b0, item.last_flag};
        end
    end

    assign fire = item_valid && (need <= free_slots);

    always_comb begin
        pend_res.start_addr = pv_reg ? pstart_reg : item.start_addr;
        pend_res.pages      = merge ? sum_pages : ppages_reg;
        pend_res.kind       = pkind_reg;
        pend_res.index      = cnt_reg;
        pend_res.final_flag = merge;

        cur_res.start_addr  = item.start_addr;
        cur_res.pages       = item.pages;
        cur_res.kind        = item.kind;
        cur_res.index       = pv_reg ? cnt1 : cnt_reg;
        cur_res.final_flag  = 1'b1;

        push.count = fire ? need : 2'd0;
        push.res0  = pv_reg ? pend_res : cur_res;
        push.res1  = cur_res;
    end

    always_comb begin
        pv_next     = pv_reg;
        pstart_next = pstart_reg;
        ppages_next = ppages_reg;
        pend_next   = pend_reg;
        pkind_next  = pkind_reg;
        cnt_next    = cnt_reg;
        if (fire) begin
            pend_next = item.end_addr;
            if (item.last_flag) begin
                pv_next  = 1'b0;
                cnt_next = '0;
            end else if (merge) begin
                ppages_next = sum_pages;
            end else begin
                pv_next     = 1'b1;
                pstart_next = item.start_addr;
                ppages_next = item.pages;
                pkind_next  = item.kind;
                cnt_next    = pv_reg ? cnt1 : cnt_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg    <= 1'b0;
            cnt_reg   <= '0;
            pkind_reg <= KIND_AVAILABLE;
        end else begin
            pv_reg    <= pv_next;
            cnt_reg   <= cnt_next;
            pkind_reg <= pkind_next;
        end
        pstart_reg <= pstart_next;
        ppages_reg <= ppages_next;
        pend_reg   <= pend_next;
    end

    // cnt2 is the index a third beat would take; two beats never pass it.
    `MRC_ASSERT_IMPLY(a_index_bound, fire && (need == 2'd2), cnt2 >= cur_res.index)
    `MRC_ASSERT_NEXT(a_last_clears, fire && item.last_flag, !pv_reg && (cnt_reg == '0))
    `MRC_ASSERT_NEXT(a_pending_kept, fire && !item.last_flag, pv_reg)

endmodule

FILE: rtl/mrc_out_queue.sv
// Two-entry output queue that takes up to two result beats a cycle.
`include "memory_region_coalescer_macros.svh"
module mrc_out_queue
    import mrc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  push_t      push,
    output logic [1:0] free_slots,
    output logic       m_valid,
    input  logic       m_ready,
    output result_t    head
);

    result_t    q0_reg, q0_next, q1_reg, q1_next;
    logic [1:0] cnt_reg, cnt_next, base_cnt;
    logic       pop;

    assign m_valid    = (cnt_reg != 2'd0);
    assign pop        = m_valid && m_ready;
    assign base_cnt   = cnt_reg - {1'b0, pop};
    assign free_slots = 2'd2 - base_cnt;
    assign head       = q0_reg;

    always_comb begin
        q0_next  = pop ? q1_reg : q0_reg;
        q1_next  = q1_reg;
        cnt_next = base_cnt + push.count;
        case (base_cnt)
            2'd0: begin
                if (push.count != 2'd0) q0_next = push.res0;
                if (push.count == 2'd2) q1_next = push.res1;
            end
            2'd1: begin
                if (push.count != 2'd0) q1_next = push.res0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    `MRC_ASSERT_IMPLY(a_cnt_bound, 1'b1, cnt_reg <= 2'd2)
    `MRC_ASSERT_IMPLY(a_push_fits, push.count != 2'd0, push.count <= free_slots)
    `MRC_ASSERT_NEXT(a_pop_drains, pop && (push.count == 2'd0), cnt_reg == $past(cnt_reg) - 2'd1)

endmodule

FILE: rtl/memory_region_coalescer.sv
// Top level of the memory region coalescer.
//
//  Channel  Direction  tdata (low bit up)                          tuser          tlast
//  s_       in         region_start[63:0], page_count[127:64]      firmware_type  last_descriptor
//  m_       out        merged_start, merged_pages, region_index    region_kind    final_region
//
// One descriptor is accepted per cycle while the queue has room, via the input register and output queue.
// A last descriptor that does not merge while a region is pending gives two beats, and the
// output port then sets the pace at one beat per cycle through the two-entry queue.
// Reset is synchronous and active low; it empties both stages and the pending region.
// A stalled output holds its beat; the input stalls once the queue cannot take all the beats
// that the held descriptor produces.
module memory_region_coalescer
    import mrc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // region_start[63:0], page_count[127:64]
    input  logic [4:0]   s_tuser,   // firmware_type[4:0]
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // merged_start[63:0], merged_pages[127:64], region_index[143:128]
    output logic [1:0]   m_tuser,   // region_kind[1:0]
    output logic         m_tlast
);

    logic       item_valid, fire;
    item_t      item;
    push_t      push;
    logic [1:0] free_slots;
    result_t    head;

    mrc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .in_start   (s_tdata[63:0]),
        .in_pages   (s_tdata[127:64]),
        .in_code    (s_tuser),
        .in_last    (s_tlast),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    mrc_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .free_slots (free_slots),
        .fire       (fire),
        .push       (push)
    );

    mrc_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .free_slots (free_slots),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .head       (head)
    );

    assign m_tdata = {head.index, head.pages, head.start_addr};
    assign m_tuser = head.kind;
    assign m_tlast = head.final_flag;

endmodule
